// ----- rtl/core/mcr_pkg.sv -----
// ----------------------------------------------------------------------------
// mcr_pkg: shared types and constants of the midpoint circle rasterizer
// Holds the stream field widths, operation codes, the controller state
// encoding and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mcr_pkg;

  // Stream field widths
  localparam int IN_COORD_W  = 12;
  localparam int PIX_W       = 15;
  localparam int IN_TDATA_W  = 4 * IN_COORD_W;
  localparam int OUT_TDATA_W = ((2 * PIX_W + 7) / 8) * 8;

  // Operation codes carried on in_tuser
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Index of the final pixel of one advance
  localparam logic [2:0] OCT_LAST = 3'd7;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQX  = 6'b000010,
    S_SQY  = 6'b000100,
    S_ROOT = 6'b001000,
    S_EMIT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;          // latch centre and distance magnitudes
    logic       sq_x;          // square the x distance
    logic       sq_y;          // add the squared y distance, arm the root
    logic       root_step;     // one digit of the square root
    logic       circle_init;   // load radius, step and decision
    logic       step_adv;      // midpoint update after the eighth pixel
    logic       clear_active;  // circle finished
    logic       done_sel;      // present the done result
    logic [2:0] octant;        // which symmetric pixel to present
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic root_done;  // all root digits resolved
    logic finish;     // no circle or the octant is complete
  } sts_t;

endpackage

// ----- rtl/core/mcr_dp.sv -----
// ----------------------------------------------------------------------------
// mcr_dp: rasterizer datapath
// Centre and distance registers, a shared squarer, a digit-by-digit integer
// square root, the midpoint step registers and the pixel offset adders.
// ----------------------------------------------------------------------------
module mcr_dp #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mcr_pkg::cmd_t               cmd,
  input  logic [mcr_pkg::IN_COORD_W-1:0] center_x,
  input  logic [mcr_pkg::IN_COORD_W-1:0] center_y,
  input  logic [mcr_pkg::IN_COORD_W-1:0] rim_x,
  input  logic [mcr_pkg::IN_COORD_W-1:0] rim_y,
  output mcr_pkg::sts_t               sts,
  output logic [mcr_pkg::PIX_W-1:0]   pixel_x,
  output logic [mcr_pkg::PIX_W-1:0]   pixel_y
);

  // Effective coordinate width after masking
  localparam int CW   = (COORD_BITS < mcr_pkg::IN_COORD_W) ? COORD_BITS : mcr_pkg::IN_COORD_W;
  localparam int SQ_W = 2 * CW + 1;   // sum of two squares
  localparam int RT_W = 2 * CW + 2;   // root accumulator and digit bit
  localparam int RW   = CW + 2;       // signed step coordinates
  localparam int DW   = CW + 4;       // signed decision value
  localparam int SW   = (DW > mcr_pkg::PIX_W) ? DW : mcr_pkg::PIX_W;

  logic [CW-1:0]          cx_r, cy_r, dx_r, dy_r;
  logic [SQ_W-1:0]        acc_r;
  logic [RT_W-1:0]        res_r, bit_r;
  logic signed [RW-1:0]   step_x_r, step_y_r;
  logic signed [DW-1:0]   dec_r;
  logic                   active_r;

  logic [CW:0]            diff_x, diff_y;
  logic [CW-1:0]          mag_x, mag_y, mul_a;
  logic [2*CW-1:0]        prod;
  logic [RT_W-1:0]        trial;
  logic                   take;
  logic [CW:0]            radius;
  logic signed [RW-1:0]   x_inc, y_dec, diff_xy, dv;
  logic signed [DW-1:0]   dv_ext, delta;
  logic                   swap, neg_a, neg_b;
  logic signed [RW-1:0]   off_a, off_b;
  logic signed [SW-1:0]   a_ext, b_ext, sum_x, sum_y;

  // Distance magnitudes from the masked coordinates
  assign diff_x = {1'b0, rim_x[CW-1:0]} - {1'b0, center_x[CW-1:0]};
  assign diff_y = {1'b0, rim_y[CW-1:0]} - {1'b0, center_y[CW-1:0]};
  assign mag_x  = diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
  assign mag_y  = diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];

  // Shared squarer
  assign mul_a = cmd.sq_y ? dy_r : dx_r;
  assign prod  = mul_a * mul_a;

  // Root digit trial
  assign trial = res_r + bit_r;
  assign take  = ({1'b0, acc_r} >= trial);
  assign radius = res_r[CW:0];

  // Midpoint update terms
  assign x_inc   = step_x_r + $signed(RW'(1));
  assign y_dec   = step_y_r - $signed(RW'(1));
  assign diff_xy = x_inc - y_dec;
  assign dv      = dec_r[DW-1] ? x_inc : diff_xy;
  assign dv_ext  = {{(DW-RW){dv[RW-1]}}, dv};
  assign delta   = {dv_ext[DW-2:0], 1'b1};

  // Setup and root registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r <= center_x[CW-1:0];
      cy_r <= center_y[CW-1:0];
      dx_r <= mag_x;
      dy_r <= mag_y;
    end
    if (cmd.sq_x) begin
      acc_r <= {1'b0, prod};
    end else if (cmd.sq_y) begin
      acc_r <= acc_r + {1'b0, prod};
      res_r <= '0;
      bit_r <= RT_W'(1) << (2 * CW);
    end else if (cmd.root_step) begin
      if (take) begin
        acc_r <= acc_r - trial[SQ_W-1:0];
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Step and decision registers
  always_ff @(posedge clk) begin
    if (cmd.circle_init) begin
      step_x_r <= '0;
      step_y_r <= $signed({1'b0, radius});
      dec_r    <= $signed({{(DW-1){1'b0}}, 1'b1}) - $signed({3'b000, radius});
    end else if (cmd.step_adv) begin
      step_x_r <= x_inc;
      if (!dec_r[DW-1]) begin
        step_y_r <= y_dec;
      end
      dec_r <= dec_r + delta;
    end
  end

  // Circle in progress flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cmd.circle_init) begin
      active_r <= 1'b1;
    end else if (cmd.clear_active) begin
      active_r <= 1'b0;
    end
  end

  assign sts.root_done = (bit_r == '0);
  assign sts.finish    = !active_r || (step_y_r < step_x_r);

  // Select the symmetric pixel: swap axes and negate per octant
  assign swap  = cmd.octant[0] ^ cmd.octant[1];
  assign neg_a = cmd.octant[2];
  assign neg_b = cmd.octant[2] ^ cmd.octant[1];
  assign off_a = swap ? step_y_r : step_x_r;
  assign off_b = swap ? step_x_r : step_y_r;
  assign a_ext = {{(SW-RW){off_a[RW-1]}}, off_a};
  assign b_ext = {{(SW-RW){off_b[RW-1]}}, off_b};
  assign sum_x = $signed({{(SW-CW){1'b0}}, cx_r}) + (neg_a ? -a_ext : a_ext);
  assign sum_y = $signed({{(SW-CW){1'b0}}, cy_r}) + (neg_b ? -b_ext : b_ext);

  assign pixel_x = cmd.done_sel ? '0 : sum_x[mcr_pkg::PIX_W-1:0];
  assign pixel_y = cmd.done_sel ? '0 : sum_y[mcr_pkg::PIX_W-1:0];

endmodule

// ----- rtl/core/mcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcr_ctrl: rasterizer controller
// Sequences the radius setup (two squares, root digits) and presents the
// eight pixels of an advance or the single done result on the output.
// ----------------------------------------------------------------------------
module mcr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_last,
  output logic          out_done,
  input  mcr_pkg::sts_t sts,
  output mcr_pkg::cmd_t cmd
);

  mcr_pkg::state_t state_r, state_nxt;
  logic [2:0]      oct_r, oct_nxt;

  // State and octant registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcr_pkg::S_IDLE;
      oct_r   <= '0;
    end else begin
      state_r <= state_nxt;
      oct_r   <= oct_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    oct_nxt        = oct_r;
    cmd            = '0;
    cmd.octant     = oct_r;
    cmd.done_sel   = (state_r == mcr_pkg::S_DONE);
    unique case (state_r)
      mcr_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_op == mcr_pkg::OP_START) begin
            cmd.load  = 1'b1;
            state_nxt = mcr_pkg::S_SQX;
          end else if (sts.finish) begin
            cmd.clear_active = 1'b1;
            state_nxt        = mcr_pkg::S_DONE;
          end else begin
            oct_nxt   = '0;
            state_nxt = mcr_pkg::S_EMIT;
          end
        end
      end
      mcr_pkg::S_SQX: begin
        cmd.sq_x  = 1'b1;
        state_nxt = mcr_pkg::S_SQY;
      end
      mcr_pkg::S_SQY: begin
        cmd.sq_y  = 1'b1;
        state_nxt = mcr_pkg::S_ROOT;
      end
      mcr_pkg::S_ROOT: begin
        if (sts.root_done) begin
          cmd.circle_init = 1'b1;
          state_nxt       = mcr_pkg::S_IDLE;
        end else begin
          cmd.root_step = 1'b1;
        end
      end
      mcr_pkg::S_EMIT: begin
        if (out_ready) begin
          if (oct_r == mcr_pkg::OCT_LAST) begin
            cmd.step_adv = 1'b1;
            state_nxt    = mcr_pkg::S_IDLE;
          end else begin
            oct_nxt = oct_r + 3'd1;
          end
        end
      end
      mcr_pkg::S_DONE: begin
        if (out_ready) begin
          state_nxt = mcr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mcr_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake flags
  assign in_ready  = (state_r == mcr_pkg::S_IDLE);
  assign out_valid = (state_r == mcr_pkg::S_EMIT) || (state_r == mcr_pkg::S_DONE);
  assign out_done  = (state_r == mcr_pkg::S_DONE);
  assign out_last  = out_done ||
                     ((state_r == mcr_pkg::S_EMIT) && (oct_r == mcr_pkg::OCT_LAST));

endmodule

// ----- rtl/core/midpoint_circle_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_top: midpoint circle rasterizer
// Computes circle radii from a centre and a rim point and steps the
// midpoint rule, emitting eight symmetric pixels per step.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser selects the request (0 start, 1 advance); in_tdata
//   carries centre and rim coordinates, read only on start.
//   A start request produces no output. It latches the centre and finds the
//   radius with a shared squarer and a digit-serial square root (W+1
//   digits, one digit per cycle, W = COORD_BITS capped at 12); in_tready
//   returns after the SQX, SQY and ROOT states, once the circle is set up.
//   An advance request yields eight pixels, one per cycle while the receiver
//   takes them, from the cycle after acceptance, tlast on the eighth; the next
//   request is taken in the cycle after that. After the octant is complete
//   (or with no circle) an advance yields one result with out_tuser set,
//   out_tlast set and zero pixels. The block handles one request at a time:
//   in_tready is low while a result is pending. A stalled receiver holds the
//   current result stable and pauses the step sequence. Reset returns the
//   block to idle with no circle in progress.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata, low bit up: center_x[11:0], center_y[11:0], rim_x[11:0], rim_y[11:0]
  input  logic [mcr_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: op
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata, low bit up: pixel_x[14:0], pixel_y[14:0], two zero pad bits
  output logic [mcr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  // out_tuser: circle_done
  output logic                             out_tuser
);

  localparam int CW = mcr_pkg::IN_COORD_W;
  localparam int PW = mcr_pkg::PIX_W;

  mcr_pkg::cmd_t    cmd;
  mcr_pkg::sts_t    sts;
  logic [PW-1:0]    pixel_x, pixel_y;

  mcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_last  (out_tlast),
    .out_done  (out_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  mcr_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .center_x (in_tdata[CW-1:0]),
    .center_y (in_tdata[2*CW-1:CW]),
    .rim_x    (in_tdata[3*CW-1:2*CW]),
    .rim_y    (in_tdata[4*CW-1:3*CW]),
    .sts      (sts),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y)
  );

  // Pack the result fields
  assign out_tdata = {{(mcr_pkg::OUT_TDATA_W - 2*PW){1'b0}}, pixel_y, pixel_x};

endmodule

// ----- rtl/core/mcr_checker.sv -----
// ----------------------------------------------------------------------------
// mcr_checker: port-level checks for the circle rasterizer
// Watches the stream ports of the top level; attached by bind below.
// ----------------------------------------------------------------------------
module mcr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mcr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Never take a request while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request taken while result pending");

  // Present a result right after an advance request
  a_advance_answers: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == mcr_pkg::OP_ADVANCE) |=> out_tvalid)
    else $error("advance request without result");

  // Done result is a lone, empty, final beat
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("malformed done result");

endmodule

bind midpoint_circle_rasterizer_top mcr_checker u_mcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ----- tb/tb_midpoint_circle_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// tb_midpoint_circle_rasterizer_top: stream testbench of the circle rasterizer
// Feeds start and advance requests from a queue, mirrors the radius search
// and the midpoint stepping in a local circle model, and compares every
// pixel and done result with the model in order, under random back-pressure.
// ----------------------------------------------------------------------------
module tb_midpoint_circle_rasterizer_top;

  typedef struct {
    logic                           op;
    logic [mcr_pkg::IN_TDATA_W-1:0] data;
  } req_t;

  typedef struct packed {
    logic signed [mcr_pkg::PIX_W-1:0] px;
    logic signed [mcr_pkg::PIX_W-1:0] py;
    logic                             last;
    logic                             done;
  } pixel_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [mcr_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tuser = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [mcr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            out_tuser;

  req_t   req_q[$];
  pixel_t pixel_q[$];
  int     req_total = 0;
  int     reqs_taken = 0;
  int     n_starts = 0;
  int     n_pixels = 0;
  int     n_done = 0;
  int     err_cnt = 0;
  logic   hold_rx = 1'b0;

  // circle state of the model
  int cir_cx = 0;
  int cir_cy = 0;
  int cir_x = 0;
  int cir_y = 0;
  int cir_d = 0;
  bit cir_active = 1'b0;

  midpoint_circle_rasterizer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor of the square root, one bit at a time from the top
  function automatic int root_floor(longint n);
    int r = 0;
    for (int b = 12; b >= 0; b--) begin
      longint t;
      t = r | (1 << b);
      if (t * t <= n) r = int'(t);
    end
    return r;
  endfunction

  function automatic void push_pixel(int px, int py, bit last, bit done);
    pixel_t p;
    p.px   = px[mcr_pkg::PIX_W-1:0];
    p.py   = py[mcr_pkg::PIX_W-1:0];
    p.last = last;
    p.done = done;
    pixel_q = {pixel_q, p};
  endfunction

  // Work out the results of one accepted request and advance the circle
  function automatic void rasterize_request(logic op, logic [mcr_pkg::IN_TDATA_W-1:0] d);
    int rx, ry;
    if (op == mcr_pkg::OP_START) begin
      cir_cx = int'(d[11:0]);
      cir_cy = int'(d[23:12]);
      rx = int'(d[35:24]) - cir_cx;
      ry = int'(d[47:36]) - cir_cy;
      cir_y = root_floor(longint'(rx) * rx + longint'(ry) * ry);
      cir_x = 0;
      cir_d = 1 - cir_y;
      cir_active = 1'b1;
      n_starts++;
      return;
    end
    // no circle, or the octant is complete
    if (!cir_active || cir_y < cir_x) begin
      cir_active = 1'b0;
      push_pixel(0, 0, 1'b1, 1'b1);
      return;
    end
    push_pixel(cir_cx + cir_x, cir_cy + cir_y, 1'b0, 1'b0);
    push_pixel(cir_cx + cir_y, cir_cy + cir_x, 1'b0, 1'b0);
    push_pixel(cir_cx + cir_y, cir_cy - cir_x, 1'b0, 1'b0);
    push_pixel(cir_cx + cir_x, cir_cy - cir_y, 1'b0, 1'b0);
    push_pixel(cir_cx - cir_x, cir_cy - cir_y, 1'b0, 1'b0);
    push_pixel(cir_cx - cir_y, cir_cy - cir_x, 1'b0, 1'b0);
    push_pixel(cir_cx - cir_y, cir_cy + cir_x, 1'b0, 1'b0);
    push_pixel(cir_cx - cir_x, cir_cy + cir_y, 1'b1, 1'b0);
    // midpoint update on the post-step values
    cir_x++;
    if (cir_d < 0) begin
      cir_d += 2 * cir_x + 1;
    end else begin
      cir_y--;
      cir_d += 2 * (cir_x - cir_y) + 1;
    end
  endfunction

  // Idle percentage per side for the current phase of the run
  function automatic int idle_pct(bit rx_side);
    if (reqs_taken < req_total / 3) return rx_side ? 75 : 20;
    if (reqs_taken < 2 * req_total / 3) return rx_side ? 20 : 75;
    return 0;
  endfunction

  function automatic void add_start(int cx, int cy, int rx, int ry);
    req_t r;
    r.op   = mcr_pkg::OP_START;
    r.data = {ry[11:0], rx[11:0], cy[11:0], cx[11:0]};
    req_q  = {req_q, r};
  endfunction

  function automatic void add_advance();
    req_t r;
    r.op   = mcr_pkg::OP_ADVANCE;
    r.data = mcr_pkg::IN_TDATA_W'({$urandom, $urandom});
    req_q  = {req_q, r};
  endfunction

  // rim coordinate near a centre coordinate, kept on the grid
  function automatic int near(int c, int spread);
    int v;
    v = c + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // Driver: present queued requests, predict on each accepted one
  always @(posedge clk) begin : drive
    req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        rasterize_request(in_tuser, in_tdata);
        reqs_taken <= reqs_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          nxt = req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.op;
          in_tdata  <= nxt.data;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk) begin : watch
    pixel_t want;
    pixel_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.px   = out_tdata[mcr_pkg::PIX_W-1:0];
        got.py   = out_tdata[2*mcr_pkg::PIX_W-1:mcr_pkg::PIX_W];
        got.last = out_tlast;
        got.done = out_tuser;
        if (pixel_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result x=%0d y=%0d last=%0b done=%0b",
                   $time, got.px, got.py, got.last, got.done);
        end else begin
          want = pixel_q.pop_front();
          if (got.px !== want.px || got.py !== want.py ||
              got.last !== want.last || got.done !== want.done) begin
            err_cnt++;
            $display("%0t: mismatch expected x=%0d y=%0d last=%0b done=%0b,",
                     $time, want.px, want.py, want.last, want.done,
                     " got x=%0d y=%0d last=%0b done=%0b",
                     got.px, got.py, got.last, got.done);
          end
          if (want.done) n_done++;
          else n_pixels++;
        end
      end
      out_tready <= !hold_rx && ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // Hold off the receiver for a long stretch so the block backs up
  initial begin
    wait (reqs_taken >= 60);
    @(negedge clk);
    hold_rx = 1'b1;
    repeat (400) @(negedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_midpoint_circle_rasterizer_top: done, errors");
    $finish;
  end

  initial begin
    int sel, cx, cy, rx, ry, rad, n, spread;

    // advance with no circle
    add_advance();
    // zero radius: centre pixels once, then done, then done again
    add_start(0, 0, 0, 0);
    repeat (3) add_advance();
    // largest radius, negative pixels
    add_start(0, 0, 4095, 4095);
    repeat (2) add_advance();
    // largest radius from the far corner
    add_start(4095, 4095, 0, 0);
    repeat (2) add_advance();
    // alternating bit patterns, restart in mid circle
    add_start(12'hAAA, 12'h555, 12'h555, 12'hAAA);
    add_advance();
    // radius one, run to completion
    add_start(2048, 2048, 2049, 2048);
    repeat (3) add_advance();
    // radius five, axis duplicates, one done past the end
    add_start(100, 200, 103, 204);
    repeat (6) add_advance();

    // random circles, mostly small and run to the end
    while (req_q.size() < 480) begin
      sel = $urandom_range(99);
      if (sel < 72) begin
        spread = $urandom_range(15);
        cx = $urandom_range(4095);
        cy = $urandom_range(4095);
        rx = near(cx, spread);
        ry = near(cy, spread);
        rad = root_floor(longint'(rx - cx) * (rx - cx) + longint'(ry - cy) * (ry - cy));
        n = 3 * rad / 4 + 2;
        if ($urandom_range(9) == 0) n = $urandom_range(n);
        add_start(cx, cy, rx, ry);
        repeat (n) add_advance();
      end else if (sel < 86) begin
        add_start($urandom_range(4095), $urandom_range(4095),
                  $urandom_range(4095), $urandom_range(4095));
        repeat ($urandom_range(1, 5)) add_advance();
      end else begin
        // noise: requests in any order
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(1)) add_advance();
          else add_start($urandom_range(4095), $urandom_range(4095),
                         $urandom_range(4095), $urandom_range(4095));
        end
      end
    end
    req_total = req_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    wait (reqs_taken == req_total);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d requests (%0d circle starts) under three stall patterns",
             req_total, n_starts);
    $display("Checked %0d pixels and %0d done results", n_pixels, n_done);
    if (err_cnt == 0) begin
      $display("tb_midpoint_circle_rasterizer_top: done, clean");
    end else begin
      $display("tb_midpoint_circle_rasterizer_top: done, errors");
    end
    $finish;
  end

endmodule
